@@ src/bde_pkg.sv @@
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and codes for the bounded deque engine: request operation
// codes, result status codes and the result record.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } result_t;

endpackage

@@ src/bde_req_if.sv @@
// ----------------------------------------------------------------------------
// bde_req_if
// Request channel: valid/ready handshake with operation and push value.
// ----------------------------------------------------------------------------
interface bde_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bde_pkg::OP_W-1:0]             operation;
  logic signed [bde_pkg::DATA_W-1:0]    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ src/bde_res_if.sv @@
// ----------------------------------------------------------------------------
// bde_res_if
// Result channel: valid/ready handshake with element, status and last flag.
// ----------------------------------------------------------------------------
interface bde_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bde_pkg::DATA_W-1:0]    element;
  logic [bde_pkg::STATUS_W-1:0]         status;
  logic                                 last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

@@ src/bde_store.sv @@
// ----------------------------------------------------------------------------
// bde_store
// Ring entry store: one write port and one registered read port with read
// enable, so the read data holds until the next read.
// ----------------------------------------------------------------------------
module bde_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [bde_pkg::DATA_W-1:0] wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic signed [bde_pkg::DATA_W-1:0] rdata
);

  logic signed [bde_pkg::DATA_W-1:0] mem [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read entry, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bde_out_reg.sv @@
// ----------------------------------------------------------------------------
// bde_out_reg
// Result output register: holds one result until the sink takes it and
// reports when a new result may be loaded.
// ----------------------------------------------------------------------------
module bde_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bde_pkg::result_t  data,
  output logic              space,
  bde_res_if.source         rsp
);

  logic             valid;
  bde_pkg::result_t held;

  // Free when empty or being drained this cycle
  assign space = !valid || rsp.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load && space) begin
      held <= data;
    end
  end

  assign rsp.valid   = valid;
  assign rsp.element = held.element;
  assign rsp.status  = held.status;
  assign rsp.last    = held.last;

endmodule

@@ src/bounded_deque_engine_core.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_engine_core
// Double-ended queue of signed 32-bit values in a ring store with a front
// index and an entry count.
// ----------------------------------------------------------------------------
// One request is handled at a time. A push or pop gives one status result
// (full on a refused push, empty on a pop of an empty queue, ok otherwise);
// codes 5 to 7 are taken and dropped without a result. A dump first issues
// a read of the store at the front entry, whose registered read data arrives
// in the next cycle, then gives one result per cycle from front to back while
// the sink keeps up, with last set on the back entry; a dump of an empty
// queue gives one empty result. Results pass through an output register, so
// a stalled sink holds back both new requests and the dump.
module bounded_deque_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst,
  bde_req_if.sink    req,
  bde_res_if.source  rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_SUM  = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic          state, state_next;
  logic [AW-1:0] front_index, front_index_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [AW-1:0] dump_idx, dump_idx_next;

  logic                              we, re;
  logic [AW-1:0]                     waddr, raddr;
  logic signed [bde_pkg::DATA_W-1:0] rdata;

  logic             load, space;
  bde_pkg::result_t res;
  logic             accept, is_full, is_empty, dump_last;
  logic [AW-1:0]    dump_idx_inc;

  // Position off entries after base, wrapped around the ring
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= CAP_SUM) begin
      s = s - CAP_SUM;
    end
    return s[AW-1:0];
  endfunction

  bde_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  bde_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .data  (res),
    .space (space),
    .rsp   (rsp)
  );

  assign req.ready    = (state == S_IDLE) && space;
  assign accept       = req.valid && req.ready;
  assign is_full      = (entry_count == CAP_CNT);
  assign is_empty     = (entry_count == '0);
  assign dump_idx_inc = dump_idx + AW'(1);
  assign dump_last    = ({1'b0, dump_idx} + (AW + 1)'(1)) == (AW + 1)'(entry_count);

  // Decode request, advance dump, drive store and result
  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    entry_count_next = entry_count;
    dump_idx_next    = dump_idx;
    we               = 1'b0;
    waddr            = front_index;
    re               = 1'b0;
    raddr            = front_index;
    load             = 1'b0;
    res.element      = '0;
    res.status       = bde_pkg::STATUS_OK;
    res.last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            bde_pkg::OP_PUSH_FRONT: begin
              load = 1'b1;
              if (is_full) begin
                res.status = bde_pkg::STATUS_FULL;
              end else begin
                front_index_next = (front_index == '0) ? LAST_POS : front_index - AW'(1);
                we               = 1'b1;
                waddr            = front_index_next;
                entry_count_next = entry_count + CW'(1);
              end
            end
            bde_pkg::OP_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                res.status = bde_pkg::STATUS_FULL;
              end else begin
                we               = 1'b1;
                waddr            = ring_pos(front_index, entry_count[AW-1:0]);
                entry_count_next = entry_count + CW'(1);
              end
            end
            bde_pkg::OP_POP_FRONT: begin
              load = 1'b1;
              if (is_empty) begin
                res.status = bde_pkg::STATUS_EMPTY;
              end else begin
                front_index_next = (front_index == LAST_POS) ? '0 : front_index + AW'(1);
                entry_count_next = entry_count - CW'(1);
              end
            end
            bde_pkg::OP_POP_BACK: begin
              load = 1'b1;
              if (is_empty) begin
                res.status = bde_pkg::STATUS_EMPTY;
              end else begin
                entry_count_next = entry_count - CW'(1);
              end
            end
            bde_pkg::OP_DUMP: begin
              if (is_empty) begin
                load       = 1'b1;
                res.status = bde_pkg::STATUS_EMPTY;
              end else begin
                re            = 1'b1;
                raddr         = front_index;
                dump_idx_next = '0;
                state_next    = S_DUMP;
              end
            end
            default: begin
              // drop undefined codes
            end
          endcase
        end
      end
      S_DUMP: begin
        // Read data for dump_idx is held in the store until taken
        if (space) begin
          load        = 1'b1;
          res.element = rdata;
          res.last    = dump_last;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            dump_idx_next = dump_idx_inc;
            re            = 1'b1;
            raddr         = ring_pos(front_index, dump_idx_inc);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      entry_count <= '0;
      dump_idx    <= '0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      entry_count <= entry_count_next;
      dump_idx    <= dump_idx_next;
    end
  end

endmodule
